// ===== design/max_queue_two_stacks_top_assert.svh =====
// Assertion macros used by max_queue_two_stacks_top.
// In simulation each macro expands to a concurrent assertion clocked by clk_i
// and disabled while rst_ni is low. In synthesis each macro expands to nothing.
`ifndef MAX_QUEUE_TWO_STACKS_TOP_ASSERT_SVH
`define MAX_QUEUE_TWO_STACKS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge.
`define MQTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define MQTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define MQTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MQTS_ASSERT(label, prop, msg)
`define MQTS_ASSERT_IMP(label, ante, cons, msg)
`define MQTS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== design/mqts_pkg.sv =====
package mqts_pkg;

  // Default number of entries in the shared store.
  localparam int unsigned DEPTH_DEFAULT = 1024;

  // Width of one queue value.
  localparam int unsigned DATA_W = 64;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_MAX   = 2'd2,
    OP_EMPTY = 2'd3
  } opcode_e;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One store entry: a value and the running maximum of its stack up to it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] rmax;
  } entry_t;

  // Signed maximum of two values.
  function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== design/max_queue_two_stacks_top.sv =====
// First-in first-out queue of signed 64-bit values that also reports its
// current maximum. Two stacks share one store of DEPTH entries: the input
// stack grows up from entry 0, the output stack grows down from DEPTH-1.
// A transaction is taken at a rising edge with start high and busy low; its
// opcode selects enqueue, dequeue, maximum query or empty query. Results come
// back on result_value_o and status_o for one cycle, marked by result_valid_o,
// and the receiver takes each one as it comes.
// Enqueue and both queries leave busy low, so the next transaction may
// follow at once; a result appears in the cycle after accept.
// Dequeue goes through the store's single read port: the popped entry is read
// first, then the new top maximum when entries remain on the output stack.
// A dequeue that finds the output stack empty first moves the n entries of the
// input stack across, one entry per cycle; every entry is moved only once.
// A successful enqueue gives no result; a full store drops the value and gives
// status 2. Dequeue or maximum on an empty queue gives status 1.
// Reset empties both stacks; the store contents are not cleared and need not
// be, as no entry is read before it has been written.
`include "max_queue_two_stacks_top_assert.svh"

module max_queue_two_stacks_top #(
  parameter int unsigned DEPTH = mqts_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode_i,
  input  logic signed [mqts_pkg::DATA_W-1:0] value_i,
  output logic                               result_valid_o,
  output logic signed [mqts_pkg::DATA_W-1:0] result_value_o,
  output logic [1:0]                         status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER,
    S_DEQ_DATA,
    S_TOP_MAX
  } state_e;

  state_e                           state_q, state_d;
  logic [CW-1:0]                    in_cnt_q, in_cnt_d;
  logic [CW-1:0]                    out_cnt_q, out_cnt_d;
  logic                             xv_q, xv_d;
  logic signed [mqts_pkg::DATA_W-1:0] in_max_q, in_max_d;
  logic signed [mqts_pkg::DATA_W-1:0] out_max_q, out_max_d;
  logic                             res_valid_q, res_valid_d;
  logic signed [mqts_pkg::DATA_W-1:0] res_value_q, res_value_d;
  logic [1:0]                       res_status_q, res_status_d;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  mqts_pkg::entry_t                 mem_wdata;
  logic                             mem_re;
  logic [AW-1:0]                    mem_raddr;
  mqts_pkg::entry_t                 mem_rdata;

  logic                             accept;
  logic                             in_empty;
  logic                             out_empty;
  logic                             q_empty;
  logic [CW:0]                      occ_w;
  logic                             q_full;
  logic [CW-1:0]                    in_top_w;
  logic [CW-1:0]                    out_free_w;
  logic [CW-1:0]                    out_top_w;
  logic [CW-1:0]                    out_next_w;
  logic signed [mqts_pkg::DATA_W-1:0] enq_max;
  logic signed [mqts_pkg::DATA_W-1:0] xfer_max;
  logic signed [mqts_pkg::DATA_W-1:0] both_max;

  // Shared store of values and running maxima.
  mqts_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Occupancy flags and store addresses derived from the stack counts.
  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign in_empty   = (in_cnt_q == '0);
  assign out_empty  = (out_cnt_q == '0);
  assign q_empty    = in_empty && out_empty;
  assign occ_w      = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};
  assign q_full     = (occ_w >= {1'b0, DEPTH_C});
  assign in_top_w   = in_cnt_q - ONE_C;
  assign out_free_w = DEPTH_C - ONE_C - out_cnt_q;
  assign out_top_w  = DEPTH_C - out_cnt_q;
  assign out_next_w = DEPTH_C - out_cnt_q + ONE_C;

  // Running maxima for a push onto either stack and for the maximum query.
  assign enq_max  = in_empty ? value_i : mqts_pkg::smax(in_max_q, value_i);
  assign xfer_max = out_empty ? mem_rdata.value
                              : mqts_pkg::smax(out_max_q, mem_rdata.value);
  assign both_max = mqts_pkg::smax(in_max_q, out_max_q);

  // Next-state logic of the controller.
  always_comb begin
    state_d      = state_q;
    in_cnt_d     = in_cnt_q;
    out_cnt_d    = out_cnt_q;
    xv_d         = xv_q;
    in_max_d     = in_max_q;
    out_max_d    = out_max_q;
    res_valid_d  = 1'b0;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mqts_pkg::opcode_e'(opcode_i))
            mqts_pkg::OP_ENQ: begin
              if (q_full) begin
                res_valid_d  = 1'b1;
                res_value_d  = '0;
                res_status_d = mqts_pkg::ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = in_cnt_q[AW-1:0];
                mem_wdata.value = value_i;
                mem_wdata.rmax  = enq_max;
                in_max_d        = enq_max;
                in_cnt_d        = in_cnt_q + ONE_C;
              end
            end
            mqts_pkg::OP_DEQ: begin
              if (q_empty) begin
                res_valid_d  = 1'b1;
                res_value_d  = '0;
                res_status_d = mqts_pkg::ST_EMPTY;
              end else if (!out_empty) begin
                mem_re    = 1'b1;
                mem_raddr = out_top_w[AW-1:0];
                state_d   = S_DEQ_DATA;
              end else begin
                xv_d    = 1'b0;
                state_d = S_XFER;
              end
            end
            mqts_pkg::OP_MAX: begin
              res_valid_d = 1'b1;
              if (q_empty) begin
                res_value_d  = '0;
                res_status_d = mqts_pkg::ST_EMPTY;
              end else begin
                res_status_d = mqts_pkg::ST_OK;
                if (out_empty) begin
                  res_value_d = in_max_q;
                end else if (in_empty) begin
                  res_value_d = out_max_q;
                end else begin
                  res_value_d = both_max;
                end
              end
            end
            mqts_pkg::OP_EMPTY: begin
              res_valid_d  = 1'b1;
              res_value_d  = q_empty ? mqts_pkg::DATA_W'(1) : '0;
              res_status_d = mqts_pkg::ST_OK;
            end
          endcase
        end
      end

      // Move the input stack across: read one entry per cycle from the top
      // of the input stack and push the previous read onto the output stack.
      S_XFER: begin
        if (!in_empty) begin
          mem_re    = 1'b1;
          mem_raddr = in_top_w[AW-1:0];
          in_cnt_d  = in_top_w;
          xv_d      = 1'b1;
        end else if (!xv_q) begin
          mem_re    = 1'b1;
          mem_raddr = out_top_w[AW-1:0];
          state_d   = S_DEQ_DATA;
        end else begin
          xv_d = 1'b0;
        end
        if (xv_q) begin
          mem_we          = 1'b1;
          mem_waddr       = out_free_w[AW-1:0];
          mem_wdata.value = mem_rdata.value;
          mem_wdata.rmax  = xfer_max;
          out_max_d       = xfer_max;
          out_cnt_d       = out_cnt_q + ONE_C;
        end
      end

      // The popped value is here; fetch the new top maximum if one remains.
      S_DEQ_DATA: begin
        res_valid_d  = 1'b1;
        res_value_d  = mem_rdata.value;
        res_status_d = mqts_pkg::ST_OK;
        out_cnt_d    = out_cnt_q - ONE_C;
        if (out_cnt_q > ONE_C) begin
          mem_re    = 1'b1;
          mem_raddr = out_next_w[AW-1:0];
          state_d   = S_TOP_MAX;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_TOP_MAX: begin
        out_max_d = mem_rdata.rmax;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, stack counts, top maxima and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_cnt_q     <= '0;
      out_cnt_q    <= '0;
      xv_q         <= 1'b0;
      in_max_q     <= '0;
      out_max_q    <= '0;
      res_valid_q  <= 1'b0;
      res_value_q  <= '0;
      res_status_q <= mqts_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      in_cnt_q     <= in_cnt_d;
      out_cnt_q    <= out_cnt_d;
      xv_q         <= xv_d;
      in_max_q     <= in_max_d;
      out_max_q    <= out_max_d;
      res_valid_q  <= res_valid_d;
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_value_o = res_value_q;
  assign status_o       = res_status_q;

  // The two stacks together never hold more than the store.
  `MQTS_ASSERT(a_occ_bound, occ_w <= {1'b0, DEPTH_C}, "stack occupancy exceeds store depth")

  // A dequeue on an empty queue is answered at once with an empty status.
  `MQTS_ASSERT_NXT(a_deq_empty, accept && opcode_i == mqts_pkg::OP_DEQ && q_empty, result_valid_o && status_o == mqts_pkg::ST_EMPTY, "empty dequeue not reported")

  // While entries move across, the input stack never grows.
  `MQTS_ASSERT_NXT(a_xfer_shrink, state_q == S_XFER, in_cnt_q <= $past(in_cnt_q), "input stack grew during transfer")

  // A read never targets the entry written in the same cycle.
  `MQTS_ASSERT_IMP(a_mem_collide, mem_we && mem_re, mem_waddr != mem_raddr, "store read and write collide")

endmodule

// ===== design/mqts_mem.sv =====
module mqts_mem #(
  parameter int unsigned DEPTH = mqts_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  mqts_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output mqts_pkg::entry_t    rdata_o
);

  logic [mqts_pkg::DATA_W-1:0] val_mem [DEPTH];
  logic [mqts_pkg::DATA_W-1:0] max_mem [DEPTH];
  mqts_pkg::entry_t            rdata_q;

  // Write port: value and running maximum are always written together.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      val_mem[waddr_i] <= wdata_i.value;
      max_mem[waddr_i] <= wdata_i.rmax;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q.value <= val_mem[raddr_i];
      rdata_q.rmax  <= max_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/max_queue_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and result channels of the max queue, predicts every
// result transaction from its own copy of the two-stack store, and compares.
module max_queue_checker
  import mqts_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     result_valid_o,
  input  logic signed [DATA_W-1:0] result_value_o,
  input  logic [1:0]               status_o,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam int StoreDepth = DEPTH_DEFAULT;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } reply_t;

  // Predicted store: the input stack grows up from entry 0, the output stack
  // grows down from the last entry. Each entry keeps its stack's running max.
  logic signed [DATA_W-1:0] data_mem [StoreDepth];
  logic signed [DATA_W-1:0] peak_mem [StoreDepth];
  int                       in_count;
  int                       out_free;
  reply_t                   replies_due[$];
  int unsigned              mismatches = 0;

  function automatic logic signed [DATA_W-1:0] greater_of(
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic reply_t make_reply(input logic signed [DATA_W-1:0] v,
                                        input status_e st);
    reply_t r;
    r.value  = v;
    r.status = st;
    return r;
  endfunction

  // Update the predicted queue for one accepted command and queue its result.
  task automatic run_queue_command(input opcode_e op, input logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] moved;
    bit in_empty;
    bit out_empty;
    in_empty  = (in_count == 0);
    out_empty = (out_free == StoreDepth - 1);
    case (op)
      OP_ENQ: begin
        if (in_count > out_free) begin
          replies_due.push_back(make_reply('0, ST_FULL));
        end else begin
          peak_mem[in_count] = (in_count == 0) ? x : greater_of(peak_mem[in_count - 1], x);
          data_mem[in_count] = x;
          in_count++;
        end
      end
      OP_DEQ: begin
        if (in_empty && out_empty) begin
          replies_due.push_back(make_reply('0, ST_EMPTY));
        end else begin
          // Refill the output stack from the input stack when it runs dry.
          if (out_empty) begin
            while (in_count > 0) begin
              in_count--;
              moved = data_mem[in_count];
              peak_mem[out_free] = (out_free == StoreDepth - 1) ?
                                   moved : greater_of(peak_mem[out_free + 1], moved);
              data_mem[out_free] = moved;
              out_free--;
            end
          end
          out_free++;
          replies_due.push_back(make_reply(data_mem[out_free], ST_OK));
        end
      end
      OP_MAX: begin
        if (in_empty && out_empty) begin
          replies_due.push_back(make_reply('0, ST_EMPTY));
        end else if (out_empty) begin
          replies_due.push_back(make_reply(peak_mem[in_count - 1], ST_OK));
        end else if (in_empty) begin
          replies_due.push_back(make_reply(peak_mem[out_free + 1], ST_OK));
        end else begin
          replies_due.push_back(make_reply(
              greater_of(peak_mem[in_count - 1], peak_mem[out_free + 1]), ST_OK));
        end
      end
      default: begin
        replies_due.push_back(make_reply((in_empty && out_empty) ? 64'sd1 : 64'sd0, ST_OK));
      end
    endcase
  endtask

  // Compare each result transaction first, then predict from the command
  // taken at the same edge; a result never answers a command of its own edge.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      in_count = 0;
      out_free = StoreDepth - 1;
      replies_due.delete();
    end else begin
      if (result_valid_o) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                   $time, result_value_o, status_o);
        end else begin
          want = replies_due.pop_front();
          if (result_value_o !== want.value) begin
            mismatches++;
            $display("%0t: result value mismatch, expected %0d, actual %0d",
                     $time, want.value, result_value_o);
          end
          if (status_o !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_o);
          end
        end
      end
      if (start && !busy)
        run_queue_command(opcode_e'(opcode_i), value_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= replies_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Drives command transactions into the max queue and gives the verdict; the
// checker beside the block predicts and compares the result transactions.
module tb;
  import mqts_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles = 20;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  opcode_e                  opcode_q = OP_ENQ;
  logic signed [DATA_W-1:0] value_q = '0;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic [1:0]               status_o;
  int unsigned              fail_count;
  int unsigned              pending;
  int unsigned              idle_cycles = 0;
  bit                       no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  max_queue_two_stacks_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_q),
    .value_i       (value_q),
    .result_valid_o(result_valid_o),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

  max_queue_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_q),
    .value_i       (value_q),
    .result_valid_o(result_valid_o),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Count cycles in which no transaction moves on either channel.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Full-width values for bit coverage, small ones so the maximum moves often.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5, 6, 7: v = DATA_W'($signed($urandom_range(0, 200)) - 100);
      8: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(DATA_W - 1){1'b0}}};
          1: v = {1'b0, {(DATA_W - 1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom), $urandom};
    endcase
    return v;
  endfunction

  function automatic opcode_e pick_op(input int enq_pct, input int deq_pct,
                                      input int max_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) return OP_ENQ;
    if (roll < enq_pct + deq_pct) return OP_DEQ;
    if (roll < enq_pct + deq_pct + max_pct) return OP_MAX;
    return OP_EMPTY;
  endfunction

  // Present one command transaction and hold it until the block takes it.
  task automatic send_cmd(input opcode_e op, input logic signed [DATA_W-1:0] x);
    int gap;
    start    <= 1'b1;
    opcode_q <= op;
    value_q  <= x;
    do @(posedge clk_i); while (busy);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mixed traffic with runs of back-to-back commands now and then.
  task automatic send_mixed(input int count, input int enq_pct, input int deq_pct,
                            input int max_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_cmd(pick_op(enq_pct, deq_pct, max_pct), pick_value());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, value extremes, a refill, and max from either stack.
    send_cmd(OP_EMPTY, '0);
    send_cmd(OP_DEQ, '1);
    send_cmd(OP_MAX, '0);
    send_cmd(OP_ENQ, {1'b1, {(DATA_W - 1){1'b0}}});
    send_cmd(OP_MAX, '0);
    send_cmd(OP_EMPTY, '1);
    send_cmd(OP_ENQ, {1'b0, {(DATA_W - 1){1'b1}}});
    send_cmd(OP_ENQ, '0);
    send_cmd(OP_ENQ, '1);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_MAX, '0);
    send_cmd(OP_ENQ, 64'sd5);
    send_cmd(OP_MAX, '0);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_MAX, '0);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_MAX, '0);
    send_cmd(OP_EMPTY, '0);
    wait_results_drained();

    // Random traffic that lets the queue grow slowly.
    send_mixed(500, 45, 30, 13);
    wait_results_drained();

    // Fill the store past full, with the odd query mixed in.
    no_gaps = 1'b1;
    for (int i = 0; i < 1030; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_cmd($urandom_range(0, 1) ? OP_MAX : OP_EMPTY, pick_value());
      send_cmd(OP_ENQ, pick_value());
    end
    wait_results_drained();

    // Draining traffic from a full store.
    send_mixed(300, 20, 55, 15);
    wait_results_drained();

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
